[hdl/rldm_pkg.sv]
// Shared constants and register codes for the radial undistortion map unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rldm_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAME_W    = 13;

  // gain factor is Q20, bounded well inside 36 bits signed
  localparam int GAIN_W     = 36;
  localparam int GAIN_LO_W  = 18;
  localparam int NORM_W     = 23;
  localparam int RAD_W      = 26;
  localparam int RAD2_W     = 31;

  // delay from a taken item to its result, in clock cycles
  localparam int LATENCY    = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_RADIAL_K1   = 3'd4,
    REG_RADIAL_K2   = 3'd5,
    REG_FRAME_W     = 3'd6,
    REG_FRAME_H     = 3'd7
  } cfg_idx_t;

  localparam logic [15:0]         CENTER_X_RST    = 16'd5875;
  localparam logic [15:0]         CENTER_Y_RST    = 16'd3974;
  localparam logic [23:0]         INV_FOCAL_X_RST = 24'd36579;
  localparam logic [23:0]         INV_FOCAL_Y_RST = 24'd36688;
  localparam logic signed [23:0]  RADIAL_K1_RST   = -24'sd297172;
  localparam logic signed [23:0]  RADIAL_K2_RST   = 24'sd77552;
  localparam logic [FRAME_W-1:0]  FRAME_W_RST     = 13'd752;
  localparam logic [FRAME_W-1:0]  FRAME_H_RST     = 13'd480;

endpackage

`default_nettype wire

[hdl/radial_lens_undistort_map_unit.sv]
// Top level of the radial lens undistortion address map.
// Instantiates rldm_cfg, rldm_gain and rldm_remap; uses rldm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   An item (out_col, out_row) is taken at each rising edge with start high
//   and busy low. busy is always low: a new item may enter every cycle.
//   Each item yields one result: done is high for one cycle with
//   dest_col/dest_row (the input passed through), src_col/src_row (the
//   source pixel to fetch) and inside_res. When inside_res is low the pixel
//   is to be painted black and src_col/src_row read 0.
//   Throughput is one item per clock. The pipeline has ten register
//   stages: offset, focal scale, square, radius, r^2 and k1 term, k2 term,
//   gain, partial products of offset times gain, center add, bounds check.
//   The receiver cannot hold results off; they are held for one cycle only.
//   Configuration: cfg_wr, cfg_addr, cfg_wdata write one register per cycle,
//   to be used only while no item is in flight.
//   Synchronous reset clears the pipeline valid bits and loads the default
//   calibration into the registers.
module radial_lens_undistort_map_unit #(
  parameter int COORD_BITS = rldm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rldm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [COORD_BITS-1:0]            out_col,
  input  wire logic [COORD_BITS-1:0]            out_row,
  output logic                                  done,
  output logic [COORD_BITS-1:0]                 dest_col,
  output logic [COORD_BITS-1:0]                 dest_row,
  output logic [COORD_BITS-1:0]                 src_col,
  output logic [COORD_BITS-1:0]                 src_row,
  output logic                                  inside_res,
  input  wire logic                             cfg_wr,
  input  wire logic [rldm_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [rldm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rldm_pkg::*;

  localparam int CW = COORD_BITS + FRAC_BITS;

  logic [CW-1:0]        center_x, center_y;
  logic [23:0]          inv_focal_x, inv_focal_y;
  logic signed [23:0]   radial_k1, radial_k2;
  logic [FRAME_W-1:0]   frame_width, frame_height;

  logic                 g_valid;
  logic [COORD_BITS-1:0] g_col, g_row;
  logic signed [CW:0]   g_dx, g_dy;
  logic signed [GAIN_W-1:0] g_gain;

  assign busy = 1'b0;

  rldm_cfg #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk, .rst, .cfg_wr, .cfg_addr, .cfg_wdata,
    .center_x, .center_y, .inv_focal_x, .inv_focal_y,
    .radial_k1, .radial_k2, .frame_width, .frame_height
  );

  rldm_gain #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_gain (
    .clk, .rst,
    .in_valid (start && !busy),
    .in_col   (out_col),
    .in_row   (out_row),
    .center_x, .center_y, .inv_focal_x, .inv_focal_y,
    .radial_k1, .radial_k2,
    .out_valid (g_valid),
    .out_col   (g_col),
    .out_row   (g_row),
    .out_dx    (g_dx),
    .out_dy    (g_dy),
    .out_gain  (g_gain)
  );

  rldm_remap #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_remap (
    .clk, .rst,
    .in_valid (g_valid),
    .in_col   (g_col),
    .in_row   (g_row),
    .in_dx    (g_dx),
    .in_dy    (g_dy),
    .in_gain  (g_gain),
    .center_x, .center_y, .frame_width, .frame_height,
    .done, .dest_col, .dest_row, .src_col, .src_row, .inside_res
  );

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  a_dest_passthru: assert property (@(posedge clk) disable iff (rst)
    done |-> (dest_col == $past(out_col, LATENCY)) &&
             (dest_row == $past(out_row, LATENCY)))
    else $error("dest coordinate does not match its item");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !inside_res) |-> (src_col == '0) && (src_row == '0))
    else $error("outside pixel with nonzero source");

  a_inside_done: assert property (@(posedge clk) disable iff (rst)
    inside_res |-> done)
    else $error("inside flag without a result");

endmodule

`default_nettype wire

[hdl/rldm_cfg.sv]
// Configuration register file for the radial undistortion map unit.
// Depends on rldm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rldm_cfg #(
  parameter int COORD_BITS = rldm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rldm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr,
  input  wire logic [rldm_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  wire logic [rldm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic [COORD_BITS+FRAC_BITS-1:0]           center_x,
  output logic [COORD_BITS+FRAC_BITS-1:0]           center_y,
  output logic [23:0]                               inv_focal_x,
  output logic [23:0]                               inv_focal_y,
  output logic signed [23:0]                        radial_k1,
  output logic signed [23:0]                        radial_k2,
  output logic [rldm_pkg::FRAME_W-1:0]              frame_width,
  output logic [rldm_pkg::FRAME_W-1:0]              frame_height
);
  import rldm_pkg::*;

  localparam int CW = COORD_BITS + FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= CW'(CENTER_X_RST);
      center_y     <= CW'(CENTER_Y_RST);
      inv_focal_x  <= INV_FOCAL_X_RST;
      inv_focal_y  <= INV_FOCAL_Y_RST;
      radial_k1    <= RADIAL_K1_RST;
      radial_k2    <= RADIAL_K2_RST;
      frame_width  <= FRAME_W_RST;
      frame_height <= FRAME_H_RST;
    end else if (cfg_wr) begin
      case (cfg_idx_t'(cfg_addr))
        REG_CENTER_X:    center_x     <= cfg_wdata[CW-1:0];
        REG_CENTER_Y:    center_y     <= cfg_wdata[CW-1:0];
        REG_INV_FOCAL_X: inv_focal_x  <= cfg_wdata[23:0];
        REG_INV_FOCAL_Y: inv_focal_y  <= cfg_wdata[23:0];
        REG_RADIAL_K1:   radial_k1    <= $signed(cfg_wdata[23:0]);
        REG_RADIAL_K2:   radial_k2    <= $signed(cfg_wdata[23:0]);
        REG_FRAME_W:     frame_width  <= cfg_wdata[FRAME_W-1:0];
        REG_FRAME_H:     frame_height <= cfg_wdata[FRAME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/rldm_gain.sv]
// Front pipeline, seven stages: offset from the principal point, normalized
// radius squared and the radial gain 1 + k1*r^2 + k2*r^4 in Q20. Uses rldm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rldm_gain #(
  parameter int COORD_BITS = rldm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rldm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire logic [COORD_BITS-1:0]                   in_col,
  input  wire logic [COORD_BITS-1:0]                   in_row,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0]         center_x,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0]         center_y,
  input  wire logic [23:0]                             inv_focal_x,
  input  wire logic [23:0]                             inv_focal_y,
  input  wire logic signed [23:0]                      radial_k1,
  input  wire logic signed [23:0]                      radial_k2,
  output logic                                         out_valid,
  output logic [COORD_BITS-1:0]                        out_col,
  output logic [COORD_BITS-1:0]                        out_row,
  output logic signed [COORD_BITS+FRAC_BITS:0]         out_dx,
  output logic signed [COORD_BITS+FRAC_BITS:0]         out_dy,
  output logic signed [rldm_pkg::GAIN_W-1:0]           out_gain
);
  import rldm_pkg::*;

  localparam int CW    = COORD_BITS + FRAC_BITS;
  localparam int DW    = CW + 1;
  localparam int PW    = CW + 24;
  localparam int STG   = 7;
  localparam int SQ_W  = 2 * NORM_W;
  localparam int K1R_W = 24 + RAD_W + 1;
  localparam int K2R_W = 24 + RAD2_W + 1;
  localparam int SUM_W = K2R_W + 1;
  localparam logic [NORM_W-1:0] NORM_CAP = NORM_W'(1) << 22;

  // payload carried alongside the arithmetic
  logic                 v     [1:STG];
  logic [COORD_BITS-1:0] col_p [1:STG];
  logic [COORD_BITS-1:0] row_p [1:STG];
  logic signed [DW-1:0]  dx_p  [1:STG];
  logic signed [DW-1:0]  dy_p  [1:STG];

  logic signed [DW-1:0]  dx_next, dy_next;
  logic [CW-1:0]         ax, ay;
  logic [PW-1:0]         px, py;
  logic [PW-1:0]         px_sh, py_sh;
  logic [NORM_W-1:0]     nx, ny;
  logic [SQ_W-1:0]       nx_sq, ny_sq;
  logic [SQ_W:0]         sq_sum;
  logic [RAD_W-1:0]      r;
  logic [2*RAD_W-1:0]    rr;
  logic signed [K1R_W-1:0] k1r, k1r_d;
  logic signed [K2R_W-1:0] k2r2;
  logic signed [SUM_W-1:0] gsum;

  assign dx_next = $signed(DW'(in_col) << FRAC_BITS) - $signed(DW'(center_x));
  assign dy_next = $signed(DW'(in_row) << FRAC_BITS) - $signed(DW'(center_y));

  assign px_sh = px >> (FRAC_BITS + 4);
  assign py_sh = py >> (FRAC_BITS + 4);
  assign nx    = (px_sh > PW'(NORM_CAP)) ? NORM_CAP : px_sh[NORM_W-1:0];
  assign ny    = (py_sh > PW'(NORM_CAP)) ? NORM_CAP : py_sh[NORM_W-1:0];

  assign sq_sum = (SQ_W+1)'(nx_sq) + (SQ_W+1)'(ny_sq);
  assign gsum   = (SUM_W'(64'sd1) <<< 40) + SUM_W'(k1r_d) + SUM_W'(k2r2);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= STG; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      v[1] <= in_valid;
      for (int k = 2; k <= STG; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    col_p[1] <= in_col;
    row_p[1] <= in_row;
    dx_p[1]  <= dx_next;
    dy_p[1]  <= dy_next;
    for (int k = 2; k <= STG; k++) begin
      col_p[k] <= col_p[k-1];
      row_p[k] <= row_p[k-1];
      dx_p[k]  <= dx_p[k-1];
      dy_p[k]  <= dy_p[k-1];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: offset magnitude
    ax    <= dx_next[DW-1] ? CW'(-dx_next) : dx_next[CW-1:0];
    ay    <= dy_next[DW-1] ? CW'(-dy_next) : dy_next[CW-1:0];
    // stage 2: scale by reciprocal focal length
    px    <= PW'(ax) * PW'(inv_focal_x);
    py    <= PW'(ay) * PW'(inv_focal_y);
    // stage 3: saturate at 4.0 and square
    nx_sq <= SQ_W'(nx) * SQ_W'(nx);
    ny_sq <= SQ_W'(ny) * SQ_W'(ny);
    // stage 4: radius squared, Q20
    r     <= sq_sum[RAD_W+19:20];
    // stage 5
    rr    <= (2*RAD_W)'(r) * (2*RAD_W)'(r);
    k1r   <= radial_k1 * $signed({1'b0, r});
    // stage 6
    k2r2  <= radial_k2 * $signed({1'b0, rr[RAD2_W+19:20]});
    k1r_d <= k1r;
    // stage 7: floor by 2^20
    out_gain <= gsum[GAIN_W+19:20];
  end

  assign out_valid = v[STG];
  assign out_col   = col_p[STG];
  assign out_row   = row_p[STG];
  assign out_dx    = dx_p[STG];
  assign out_dy    = dy_p[STG];

endmodule

`default_nettype wire

[hdl/rldm_remap.sv]
// Back pipeline, three stages: offset times gain in split partial products,
// add back the center, bounds check and output registers. Uses rldm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rldm_remap #(
  parameter int COORD_BITS = rldm_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rldm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    in_valid,
  input  wire logic [COORD_BITS-1:0]                   in_col,
  input  wire logic [COORD_BITS-1:0]                   in_row,
  input  wire logic signed [COORD_BITS+FRAC_BITS:0]    in_dx,
  input  wire logic signed [COORD_BITS+FRAC_BITS:0]    in_dy,
  input  wire logic signed [rldm_pkg::GAIN_W-1:0]      in_gain,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0]         center_x,
  input  wire logic [COORD_BITS+FRAC_BITS-1:0]         center_y,
  input  wire logic [rldm_pkg::FRAME_W-1:0]            frame_width,
  input  wire logic [rldm_pkg::FRAME_W-1:0]            frame_height,
  output logic                                         done,
  output logic [COORD_BITS-1:0]                        dest_col,
  output logic [COORD_BITS-1:0]                        dest_row,
  output logic [COORD_BITS-1:0]                        src_col,
  output logic [COORD_BITS-1:0]                        src_row,
  output logic                                         inside_res
);
  import rldm_pkg::*;

  localparam int CW    = COORD_BITS + FRAC_BITS;
  localparam int DW    = CW + 1;
  localparam int GH_W  = GAIN_W - GAIN_LO_W;
  localparam int PL_W  = DW + GAIN_LO_W + 1;
  localparam int PH_W  = DW + GH_W;
  localparam int FP_W  = DW + GAIN_W + 1;
  localparam int SW    = FP_W - 20 + 1;
  localparam int CMP_W = ((COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W) + 1;
  localparam int TOP   = FRAC_BITS + COORD_BITS;

  logic                  v8, v9;
  logic [COORD_BITS-1:0] col8, row8, col9, row9;
  logic signed [PL_W-1:0] plo_x, plo_y;
  logic signed [PH_W-1:0] phi_x, phi_y;
  logic signed [FP_W-1:0] fx, fy;
  logic signed [SW-1:0]   sx_next, sy_next, sx, sy;
  logic [COORD_BITS-1:0]  sc, sr;
  logic                   in_frame;

  // gain = hi * 2^18 + lo, lo unsigned
  always_ff @(posedge clk) begin
    plo_x <= in_dx * $signed({1'b0, in_gain[GAIN_LO_W-1:0]});
    plo_y <= in_dy * $signed({1'b0, in_gain[GAIN_LO_W-1:0]});
    phi_x <= in_dx * $signed(in_gain[GAIN_W-1:GAIN_LO_W]);
    phi_y <= in_dy * $signed(in_gain[GAIN_W-1:GAIN_LO_W]);
    col8  <= in_col;
    row8  <= in_row;
    sx    <= sx_next;
    sy    <= sy_next;
    col9  <= col8;
    row9  <= row8;
  end

  assign fx = (FP_W'(phi_x) <<< GAIN_LO_W) + FP_W'(plo_x);
  assign fy = (FP_W'(phi_y) <<< GAIN_LO_W) + FP_W'(plo_y);
  assign sx_next = $signed(SW'(center_x)) + SW'(fx >>> 20);
  assign sy_next = $signed(SW'(center_y)) + SW'(fy >>> 20);

  assign sc = sx[TOP-1:FRAC_BITS];
  assign sr = sy[TOP-1:FRAC_BITS];
  // negative or beyond coordinate range fails the upper-bit test
  assign in_frame = (sx[SW-1:TOP] == '0) && (sy[SW-1:TOP] == '0) &&
                    (CMP_W'(sc) < CMP_W'(frame_width)) &&
                    (CMP_W'(sr) < CMP_W'(frame_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      v8         <= 1'b0;
      v9         <= 1'b0;
      done       <= 1'b0;
      inside_res <= 1'b0;
    end else begin
      v8         <= in_valid;
      v9         <= v8;
      done       <= v9;
      inside_res <= v9 && in_frame;
    end
  end

  always_ff @(posedge clk) begin
    dest_col <= col9;
    dest_row <= row9;
    src_col  <= in_frame ? sc : '0;
    src_row  <= in_frame ? sr : '0;
  end

endmodule

`default_nettype wire

[tb/tb_radial_lens_undistort_map_unit.sv]
// Testbench for radial_lens_undistort_map_unit: drives output pixel positions and
// checks each source fetch address against a fixed-point predictor of the k1/k2 map.
// Depends on rldm_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module tb_radial_lens_undistort_map_unit;
  import rldm_pkg::*;

  localparam int COORD_W     = COORD_BITS_DEF;
  localparam int FRAC_W      = FRAC_BITS_DEF;
  localparam longint COORD_MAX = (64'd1 << COORD_W) - 1;
  localparam longint NORM_SAT  = 64'd1 << 22;
  localparam longint UNITY_Q40 = 64'd1 << 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 95;

  typedef struct {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [23:0]        ifx;
    logic [23:0]        ify;
    logic signed [23:0] k1;
    logic signed [23:0] k2;
    logic [12:0]        fw;
    logic [12:0]        fh;
  } calib_t;

  typedef struct {
    logic [COORD_W-1:0] dcol;
    logic [COORD_W-1:0] drow;
    logic [COORD_W-1:0] scol;
    logic [COORD_W-1:0] srow;
    logic               in_flag;
  } fetch_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [COORD_W-1:0] out_col = '0;
  logic [COORD_W-1:0] out_row = '0;
  logic cfg_wr = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic busy, done, inside_res;
  logic [COORD_W-1:0] dest_col, dest_row, src_col, src_row;

  calib_t calib;
  fetch_t fetch_q[$];
  int mismatch_count = 0;
  int cycle_count = 0;

  radial_lens_undistort_map_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .out_col(out_col), .out_row(out_row),
    .done(done), .dest_col(dest_col), .dest_row(dest_row),
    .src_col(src_col), .src_row(src_row), .inside_res(inside_res),
    .cfg_wr(cfg_wr), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_radial_lens_undistort_map_unit: errors");
      $finish;
    end
  end

  // |offset| * 1/f, Q.FRAC -> Q20, clamped at 4.0
  function automatic longint norm_offset(longint d, logic [23:0] inv_f);
    longint mag, n;
    mag = (d < 0) ? -d : d;
    n = (mag * longint'(inv_f)) >> (FRAC_W + 4);
    return (n > NORM_SAT) ? NORM_SAT : n;
  endfunction

  function automatic fetch_t predict_fetch(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    fetch_t res;
    longint dx, dy, nx, ny, rad, rad2, gain, sx, sy, sc, sr;
    bit in_frame;
    dx = (longint'(col) <<< FRAC_W) - longint'(calib.cx);
    dy = (longint'(row) <<< FRAC_W) - longint'(calib.cy);
    nx = norm_offset(dx, calib.ifx);
    ny = norm_offset(dy, calib.ify);
    rad = (nx * nx + ny * ny) >> 20;
    rad2 = (rad * rad) >> 20;
    gain = (UNITY_Q40 + longint'(calib.k1) * rad + longint'(calib.k2) * rad2) >>> 20;
    sx = longint'(calib.cx) + ((dx * gain) >>> 20);
    sy = longint'(calib.cy) + ((dy * gain) >>> 20);
    in_frame = 1'b0;
    sc = 0;
    sr = 0;
    if (sx >= 0 && sy >= 0) begin
      sc = sx >>> FRAC_W;
      sr = sy >>> FRAC_W;
      in_frame = sc < longint'(calib.fw) && sr < longint'(calib.fh) &&
                 sc <= COORD_MAX && sr <= COORD_MAX;
    end
    res.dcol = col;
    res.drow = row;
    res.scol = in_frame ? COORD_W'(sc) : '0;
    res.srow = in_frame ? COORD_W'(sr) : '0;
    res.in_flag = in_frame;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    fetch_t exp_r;
    if (!rst && done) begin
      if (fetch_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual dest (%0d,%0d) src (%0d,%0d)",
                 $time, dest_col, dest_row, src_col, src_row);
        mismatch_count++;
      end else begin
        exp_r = fetch_q.pop_front();
        check_field("dest_col", exp_r.dcol, dest_col);
        check_field("dest_row", exp_r.drow, dest_row);
        check_field("src_col", exp_r.scol, src_col);
        check_field("src_row", exp_r.srow, src_row);
        check_field("inside_res", exp_r.in_flag, inside_res);
      end
    end
  end

  // called at a falling edge; start stays high on return
  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    fetch_t exp_r;
    exp_r = predict_fetch(col, row);
    start <= 1'b1;
    out_col <= col;
    out_row <= row;
    do @(posedge clk); while (busy);
    fetch_q.push_back(exp_r);
    @(negedge clk);
  endtask

  task automatic idle_gap(bit allow);
    int p, n;
    if (!allow) return;
    p = $urandom_range(0, 99);
    if (p < 45) n = 0;
    else if (p < 85) n = $urandom_range(1, 3);
    else if (p < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (fetch_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // pipeline must be empty when this is called
  task automatic apply_calib(calib_t c);
    write_reg(REG_CENTER_X, CFG_DATA_W'(c.cx));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(c.cy));
    write_reg(REG_INV_FOCAL_X, c.ifx);
    write_reg(REG_INV_FOCAL_Y, c.ify);
    write_reg(REG_RADIAL_K1, c.k1);
    write_reg(REG_RADIAL_K2, c.k2);
    write_reg(REG_FRAME_W, CFG_DATA_W'(c.fw));
    write_reg(REG_FRAME_H, CFG_DATA_W'(c.fh));
    cfg_wr <= 1'b0;
    calib = c;
    @(negedge clk);
  endtask

  function automatic calib_t reset_calib();
    calib_t c;
    c.cx = CENTER_X_RST;
    c.cy = CENTER_Y_RST;
    c.ifx = INV_FOCAL_X_RST;
    c.ify = INV_FOCAL_Y_RST;
    c.k1 = RADIAL_K1_RST;
    c.k2 = RADIAL_K2_RST;
    c.fw = FRAME_W_RST;
    c.fh = FRAME_H_RST;
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(logic [12:0] extent);
    int lim;
    lim = (extent > 13'd4096) ? 4096 : int'(extent);
    if (lim == 0 || $urandom_range(0, 9) < 3) return COORD_W'($urandom);
    return COORD_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic test_reset_calibration();
    calib = reset_calib();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    idle_gap(1'b1);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    idle_gap(1'b1);
    send_pixel(12'd367, 12'd248);
    send_pixel(12'd751, 12'd479);
    send_pixel(12'd300, 12'd100);
    drain_pipeline();
  endtask

  // zero coefficients give unity gain: source equals destination
  task automatic test_identity_and_range();
    calib_t c;
    c = reset_calib();
    c.k1 = '0;
    c.k2 = '0;
    c.fw = 13'd4096;
    c.fh = 13'd4096;
    apply_calib(c);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd4095);
    drain_pipeline();
    // pushed past the coordinate range with a frame register larger than it
    c.fw = 13'd8191;
    c.fh = 13'd8191;
    c.cx = '0;
    c.cy = '0;
    c.k1 = 24'sd1048576;
    apply_calib(c);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd1, 12'd1);
    drain_pipeline();
  endtask

  task automatic test_empty_and_tiny_frame();
    calib_t c;
    c = reset_calib();
    c.fw = '0;
    apply_calib(c);
    send_pixel(12'd367, 12'd248);
    send_pixel(12'd0, 12'd0);
    drain_pipeline();
    c.fw = 13'd1;
    c.fh = 13'd1;
    c.k1 = '0;
    c.k2 = '0;
    apply_calib(c);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    send_pixel(12'd0, 12'd1);
    drain_pipeline();
  endtask

  // saturated radius with extreme coefficients, including folding to negative source
  task automatic test_coefficient_extremes();
    calib_t c;
    c = reset_calib();
    c.ifx = 24'hFFFFFF;
    c.ify = 24'hFFFFFF;
    c.k1 = 24'h800000;
    c.k2 = 24'h800000;
    apply_calib(c);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd200, 12'd300);
    drain_pipeline();
    c.k1 = 24'h7FFFFF;
    c.k2 = 24'h7FFFFF;
    c.cx = 16'hFFFF;
    c.cy = 16'hFFFF;
    c.fw = 13'd4096;
    c.fh = 13'd4096;
    apply_calib(c);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    drain_pipeline();
    c = reset_calib();
    c.ifx = '0;
    c.ify = '0;
    c.cx = '0;
    c.cy = '0;
    apply_calib(c);
    send_pixel(12'd10, 12'd20);
    drain_pipeline();
  endtask

  task automatic test_random_calibrations();
    calib_t c;
    int focal;
    bit gaps;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph % 3 == 2) begin
        c.cx = 16'($urandom);
        c.cy = 16'($urandom);
        c.ifx = 24'($urandom);
        c.ify = 24'($urandom);
        c.k1 = 24'($urandom);
        c.k2 = 24'($urandom);
        c.fw = 13'($urandom_range(0, 8191));
        c.fh = 13'($urandom_range(0, 8191));
      end else begin
        c.fw = 13'($urandom_range(16, 4096));
        c.fh = 13'($urandom_range(16, 4096));
        c.cx = 16'($urandom_range(0, int'(c.fw) * 16 - 1));
        c.cy = 16'($urandom_range(0, int'(c.fh) * 16 - 1));
        focal = $urandom_range(100, 3000);
        c.ifx = 24'(32'd16777216 / focal);
        focal = $urandom_range(100, 3000);
        c.ify = 24'(32'd16777216 / focal);
        c.k1 = 24'(int'($urandom_range(0, 1048576)) - 524288);
        c.k2 = 24'(int'($urandom_range(0, 524288)) - 262144);
      end
      apply_calib(c);
      gaps = !(ph == 0 || ph == 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_pixel(pick_coord(c.fw), pick_coord(c.fh));
        // hold off until the pipeline has emptied
        if (i == PHASE_ITEMS / 2 || $urandom_range(0, 199) == 0) drain_pipeline();
        else idle_gap(gaps);
      end
      drain_pipeline();
    end
  endtask

  initial begin
    calib = reset_calib();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_calibration();
    test_identity_and_range();
    test_empty_and_tiny_frame();
    test_coefficient_extremes();
    test_random_calibrations();
    drain_pipeline();
    if (mismatch_count == 0)
      $display("tb_radial_lens_undistort_map_unit: clean");
    else
      $display("tb_radial_lens_undistort_map_unit: errors");
    $finish;
  end

endmodule
